>>> rtl/core/qrhl_pkg.sv
// Shared types and constants of the quadruplet ratio hinge loss block.
package qrhl_pkg;

    localparam int ELEM_W   = 16;
    localparam int SQ_W     = 32;
    localparam int DIST_W   = 48;
    localparam int GAIN_W   = 16;
    localparam int LOSS_W   = 32;
    localparam int TOTAL_W  = 40;
    localparam int COUNT_W  = 9;
    localparam int PROD_W   = 64;
    localparam int NUM_W    = 72;
    localparam int HALF_W   = 24;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // One finished sample handed from the front to the back.
    typedef struct packed {
        logic [DIST_W-1:0] ref_dist;
        logic [DIST_W-1:0] cand_dist;
        logic              batch_end;
    } t_entry;

    // Divide request: quotient is floor(num / den), saturated to LOSS_W bits.
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [DIST_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [LOSS_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/core/qrhl_front.sv
// Front end: squares the pair differences and accumulates the two distances.
module qrhl_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [qrhl_pkg::ELEM_W-1:0]  i_ref_first,
    input  logic signed [qrhl_pkg::ELEM_W-1:0]  i_ref_second,
    input  logic signed [qrhl_pkg::ELEM_W-1:0]  i_cand_first,
    input  logic signed [qrhl_pkg::ELEM_W-1:0]  i_cand_second,
    input  logic                                i_vector_end,
    input  logic                                i_batch_end,
    input  logic [qrhl_pkg::Q_CNT_W-1:0]        i_q_count,
    output logic                                o_push,
    output qrhl_pkg::t_entry                    o_entry
);

    localparam int DW = qrhl_pkg::DIST_W;
    localparam int SW = qrhl_pkg::SQ_W;
    localparam int CW = qrhl_pkg::Q_CNT_W;

    logic signed [qrhl_pkg::ELEM_W:0]     w_ref_d;
    logic signed [qrhl_pkg::ELEM_W:0]     w_cand_d;
    logic signed [2*qrhl_pkg::ELEM_W+1:0] w_ref_sq;
    logic signed [2*qrhl_pkg::ELEM_W+1:0] w_cand_sq;
    logic                                 w_accept;
    logic [CW-1:0]                        w_level;
    logic [DW:0]                          w_ref_sum;
    logic [DW:0]                          w_cand_sum;
    logic [DW-1:0]                        w_ref_next;
    logic [DW-1:0]                        w_cand_next;

    logic          r_a_valid;
    logic [SW-1:0] r_a_ref_sq;
    logic [SW-1:0] r_a_cand_sq;
    logic          r_a_vend;
    logic          r_a_bend;
    logic [DW-1:0] r_ref_sum;
    logic [DW-1:0] r_cand_sum;

    assign w_ref_d   = {i_ref_first[qrhl_pkg::ELEM_W-1], i_ref_first}
                     - {i_ref_second[qrhl_pkg::ELEM_W-1], i_ref_second};
    assign w_cand_d  = {i_cand_first[qrhl_pkg::ELEM_W-1], i_cand_first}
                     - {i_cand_second[qrhl_pkg::ELEM_W-1], i_cand_second};
    assign w_ref_sq  = w_ref_d * w_ref_d;
    assign w_cand_sq = w_cand_d * w_cand_d;

    assign o_push  = r_a_valid & r_a_vend;

    // Leave room for the sample in flight and the one accepted now.
    assign w_level    = i_q_count + CW'(o_push);
    assign o_in_stall = (w_level >= CW'(qrhl_pkg::Q_DEPTH));
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_ref_sum   = {1'b0, r_ref_sum} + {{(DW+1-SW){1'b0}}, r_a_ref_sq};
    assign w_cand_sum  = {1'b0, r_cand_sum} + {{(DW+1-SW){1'b0}}, r_a_cand_sq};
    assign w_ref_next  = w_ref_sum[DW] ? {DW{1'b1}} : w_ref_sum[DW-1:0];
    assign w_cand_next = w_cand_sum[DW] ? {DW{1'b1}} : w_cand_sum[DW-1:0];

    assign o_entry.ref_dist  = w_ref_next;
    assign o_entry.cand_dist = w_cand_next;
    assign o_entry.batch_end = r_a_bend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_ref_sum  <= '0;
            r_cand_sum <= '0;
        end else begin
            r_a_valid <= w_accept;
            if (r_a_valid) begin
                if (r_a_vend) begin
                    r_ref_sum  <= '0;
                    r_cand_sum <= '0;
                end else begin
                    r_ref_sum  <= w_ref_next;
                    r_cand_sum <= w_cand_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_ref_sq  <= w_ref_sq[SW-1:0];
            r_a_cand_sq <= w_cand_sq[SW-1:0];
            r_a_vend    <= i_vector_end;
            r_a_bend    <= i_batch_end & i_vector_end;
        end
    end

endmodule

>>> rtl/core/qrhl_queue.sv
// Short register queue of finished samples between front and back.
module qrhl_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  qrhl_pkg::t_entry              i_entry,
    input  logic                          i_pop,
    output qrhl_pkg::t_entry              o_head,
    output logic                          o_empty,
    output logic [qrhl_pkg::Q_CNT_W-1:0]  o_count
);

    localparam int PW = qrhl_pkg::Q_PTR_W;
    localparam int CW = qrhl_pkg::Q_CNT_W;

    qrhl_pkg::t_entry r_mem [qrhl_pkg::Q_DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        logic [PW-1:0] n;
        n = (p == PW'(qrhl_pkg::Q_DEPTH - 1)) ? '0 : p + PW'(1);
        return n;
    endfunction

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_next(r_rd);
            end
            r_count <= r_count + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CW'(qrhl_pkg::Q_DEPTH)))
        else $error("sample queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("sample queue read while empty");

endmodule

>>> rtl/core/qrhl_div.sv
// Restoring divider, one quotient bit per cycle, saturating at 32 bits.
module qrhl_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qrhl_pkg::t_div_req i_req,
    output qrhl_pkg::t_div_rsp o_rsp
);

    localparam int DW = qrhl_pkg::DIST_W;
    localparam int LW = qrhl_pkg::LOSS_W;
    localparam int NW = qrhl_pkg::NUM_W;
    localparam int KW = qrhl_pkg::DIV_CNT_W;

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic          w_sat;

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [LW-1:0] r_lo;

    // Quotient would not fit when the upper dividend part reaches the divisor.
    assign w_sat   = {{(DW-(NW-LW)){1'b0}}, i_req.num[NW-1:LW]} >= i_req.den;
    assign w_trial = {r_rem, r_lo[LW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (w_sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= KW'(qrhl_pkg::DIV_STEPS - 1);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - KW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            if (w_sat) begin
                r_lo <= '1;
            end else begin
                r_rem <= {{(DW-(NW-LW)){1'b0}}, i_req.num[NW-1:LW]};
                r_lo  <= i_req.num[LW-1:0];
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_lo  <= {r_lo[LW-2:0], w_ge};
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divide started while busy");

endmodule

>>> rtl/core/qrhl_back.sv
// Back end: ratio loss per sample, batch total and the result register.
module qrhl_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [qrhl_pkg::GAIN_W-1:0]   i_cfg_data,
    input  qrhl_pkg::t_entry              i_head,
    input  logic                          i_q_empty,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [qrhl_pkg::LOSS_W-1:0]   o_sample_loss,
    output logic                          o_zero_reference,
    output logic                          o_batch_valid,
    output logic [qrhl_pkg::LOSS_W-1:0]   o_batch_loss
);

    localparam int DW = qrhl_pkg::DIST_W;
    localparam int GW = qrhl_pkg::GAIN_W;
    localparam int LW = qrhl_pkg::LOSS_W;
    localparam int TW = qrhl_pkg::TOTAL_W;
    localparam int CW = qrhl_pkg::COUNT_W;
    localparam int PW = qrhl_pkg::PROD_W;
    localparam int NW = qrhl_pkg::NUM_W;
    localparam int HW = qrhl_pkg::HALF_W;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_MUL_LO     = 4'd1;
    localparam logic [3:0] S_MUL_HI     = 4'd2;
    localparam logic [3:0] S_SUM        = 4'd3;
    localparam logic [3:0] S_LOSS_GO    = 4'd4;
    localparam logic [3:0] S_LOSS_WAIT  = 4'd5;
    localparam logic [3:0] S_ACCUM      = 4'd6;
    localparam logic [3:0] S_BATCH_GO   = 4'd7;
    localparam logic [3:0] S_BATCH_WAIT = 4'd8;
    localparam logic [3:0] S_OUT        = 4'd9;

    logic [3:0]    r_state;
    logic [GW-1:0] r_gain;
    logic [DW-1:0] r_old;
    logic [DW-1:0] r_gap;
    logic          r_bend;
    logic [GW+HW-1:0] r_plo;
    logic [GW+HW-1:0] r_phi;
    logic [PW-1:0] r_n;
    logic [LW-1:0] r_loss;
    logic          r_zero;
    logic [LW-1:0] r_blos;
    logic [TW-1:0] r_total;
    logic [CW-1:0] r_count;

    logic          r_out_valid;
    logic [LW-1:0] r_o_loss;
    logic          r_o_zero;
    logic          r_o_bvalid;
    logic [LW-1:0] r_o_blos;

    logic [GW+HW-1:0]   w_mul;
    logic [TW:0]        w_total_sum;
    logic               w_load;
    qrhl_pkg::t_div_req w_div_req;
    qrhl_pkg::t_div_rsp w_div_rsp;

    // One shared multiplier over the two halves of the distance gap.
    assign w_mul = r_gain * ((r_state == S_MUL_LO) ? r_gap[HW-1:0] : r_gap[DW-1:HW]);

    assign w_total_sum = {1'b0, r_total} + {{(TW+1-LW){1'b0}}, r_loss};
    assign w_load      = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign o_pop       = (r_state == S_IDLE) && !i_q_empty;

    assign w_div_req.start = (r_state == S_LOSS_GO) || (r_state == S_BATCH_GO);
    assign w_div_req.num   = (r_state == S_LOSS_GO) ? {r_n, {(NW-PW){1'b0}}}
                                                    : {{(NW-TW){1'b0}}, r_total};
    assign w_div_req.den   = (r_state == S_LOSS_GO) ? r_old
                                                    : {{(DW-CW-1){1'b0}}, r_count, 1'b0};

    qrhl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gain  <= GW'(256);
            r_total <= '0;
            r_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_gain <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        if (i_head.ref_dist == '0) begin
                            r_state <= S_ACCUM;
                        end else if (i_head.cand_dist <= i_head.ref_dist) begin
                            r_state <= S_ACCUM;
                        end else begin
                            r_state <= S_MUL_LO;
                        end
                    end
                end
                S_MUL_LO:  r_state <= S_MUL_HI;
                S_MUL_HI:  r_state <= S_SUM;
                S_SUM:     r_state <= S_LOSS_GO;
                S_LOSS_GO: r_state <= S_LOSS_WAIT;
                S_LOSS_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_state <= S_ACCUM;
                    end
                end
                S_ACCUM: begin
                    r_total <= w_total_sum[TW] ? {TW{1'b1}} : w_total_sum[TW-1:0];
                    if (r_count != {CW{1'b1}}) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= r_bend ? S_BATCH_GO : S_OUT;
                end
                S_BATCH_GO: r_state <= S_BATCH_WAIT;
                S_BATCH_WAIT: begin
                    if (w_div_rsp.done) begin
                        r_total <= '0;
                        r_count <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_old  <= i_head.ref_dist;
                r_gap  <= i_head.cand_dist - i_head.ref_dist;
                r_bend <= i_head.batch_end;
                r_zero <= (i_head.ref_dist == '0);
                r_loss <= (i_head.ref_dist == '0) ? {LW{1'b1}} : '0;
                r_blos <= '0;
            end
            S_MUL_LO: r_plo <= w_mul;
            S_MUL_HI: r_phi <= w_mul;
            S_SUM:    r_n   <= {r_phi, {HW{1'b0}}} + {{(PW-GW-HW){1'b0}}, r_plo};
            S_LOSS_WAIT: begin
                if (w_div_rsp.done) begin
                    r_loss <= w_div_rsp.quot;
                end
            end
            S_BATCH_WAIT: begin
                if (w_div_rsp.done) begin
                    r_blos <= w_div_rsp.quot;
                end
            end
            default: begin
            end
        endcase
    end

    // Result register: hold while stalled, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_loss   <= r_loss;
            r_o_zero   <= r_zero;
            r_o_bvalid <= r_bend;
            r_o_blos   <= r_blos;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sample_loss    = r_o_loss;
    assign o_zero_reference = r_o_zero;
    assign o_batch_valid    = r_o_bvalid;
    assign o_batch_loss     = r_o_blos;

    a_zero_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_reference) |-> (o_sample_loss == {LW{1'b1}}))
        else $error("zero reference without saturated loss");

    a_batch_loss_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_batch_valid) |-> (o_batch_loss == '0))
        else $error("batch loss set outside batch end");

endmodule

>>> rtl/core/quadruplet_ratio_hinge_loss_top.sv
// Top level of the quadruplet distance ratio hinge loss block.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------------------
//   in      | request   | i_in_valid / o_in_stall    | four Q4.12 elements, vector/batch end
//   out     | result    | o_out_valid / i_out_stall  | sample loss, zero flag, batch loss
//   cfg     | write     | i_cfg_valid / o_cfg_ready  | margin gain, Q8.8
//
// The front takes one element per cycle unless stalled; a sample end is queued (four deep)
// for the back. The back takes a new sample only once the last result is loaded; the
// one-bit-per-cycle divider forms the sample loss when one is due and, at a batch end,
// the batch loss, and the back also waits while the result register is stalled.
// Reset is synchronous, active low; nothing needs a clearing pass.
// Input stalls while the sample queue, counting a sample about to enter, is full;
// the result register frees the back.
module quadruplet_ratio_hinge_loss_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [qrhl_pkg::ELEM_W-1:0]  i_ref_first,
    input  logic signed [qrhl_pkg::ELEM_W-1:0]  i_ref_second,
    input  logic signed [qrhl_pkg::ELEM_W-1:0]  i_cand_first,
    input  logic signed [qrhl_pkg::ELEM_W-1:0]  i_cand_second,
    input  logic                                i_vector_end,
    input  logic                                i_batch_end,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [qrhl_pkg::LOSS_W-1:0]         o_sample_loss,
    output logic                                o_zero_reference,
    output logic                                o_batch_valid,
    output logic [qrhl_pkg::LOSS_W-1:0]         o_batch_loss,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qrhl_pkg::GAIN_W-1:0]         i_cfg_data
);

    logic                           w_push;
    logic                           w_pop;
    logic                           w_empty;
    logic [qrhl_pkg::Q_CNT_W-1:0]   w_count;
    qrhl_pkg::t_entry               w_entry;
    qrhl_pkg::t_entry               w_head;

    assign o_cfg_ready = 1'b1;

    qrhl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_ref_first   (i_ref_first),
        .i_ref_second  (i_ref_second),
        .i_cand_first  (i_cand_first),
        .i_cand_second (i_cand_second),
        .i_vector_end  (i_vector_end),
        .i_batch_end   (i_batch_end),
        .i_q_count     (w_count),
        .o_push        (w_push),
        .o_entry       (w_entry)
    );

    qrhl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_empty),
        .o_count (w_count)
    );

    qrhl_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_head           (w_head),
        .i_q_empty        (w_empty),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_sample_loss    (o_sample_loss),
        .o_zero_reference (o_zero_reference),
        .o_batch_valid    (o_batch_valid),
        .o_batch_loss     (o_batch_loss)
    );

endmodule
